[rtl/core/lifo_rm_pkg.sv]
// Shared types and constants for the LIFO stack with value removal.
package lifo_rm_pkg;

    localparam int unsigned CAP_W       = 7;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned OUT_TUSER_W = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_READ_TOP,
        ST_TOP_WAIT
    } state_t;

endpackage

[rtl/core/lifo_stack_with_value_removal_core.sv]
// Bounded LIFO stack of signed words with push, pop and remove-by-value.
//
// One item at a time: s_tready is high only while the sequencer is idle. Every
// operation ends with a read of the new top entry from the stack memory, which
// has one write port and one registered read port; no top entry is read when
// the stack is empty afterwards. A remove reads and compares the entries from
// the top down to the match (all entries when absent), then moves each entry
// above the match down one place with a read and a write, since compare and
// move both go through the single read port. If the output register still
// holds an earlier result, the finished item waits and the input stays closed
// until m_tready frees it. A finished item waits in the output register while
// the next item is accepted. Entries are not cleared at reset; only entries
// below the count are ever used. The capacity register limits pushes to
// min(capacity, DEPTH).
module lifo_stack_with_value_removal_core #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [31:0] value
    input  logic [lifo_rm_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [1:0] operation
    input  logic [lifo_rm_pkg::IN_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] popped_value, [63:32] top_value, [70:64] entry_count, [71] is_empty
    output logic [lifo_rm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [lifo_rm_pkg::OUT_TUSER_W-1:0]  m_tuser,
    input  logic                                 cfg_wen,
    input  logic [lifo_rm_pkg::CAP_W-1:0]        cfg_wdata
);
    import lifo_rm_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned EW = CW + CAP_W;

    logic [WORD_W-1:0] mem [DEPTH];

    state_t            state_reg, state_next;
    logic              fin_reg, fin_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic [WORD_W-1:0] popped_reg, popped_next;
    logic [WORD_W-1:0] top_reg, top_next;
    status_t           status_reg, status_next;
    logic [CAP_W-1:0]  capacity_reg;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg;
    logic                   out_load;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [AW-1:0]     mem_ra;
    logic [WORD_W-1:0] mem_wd;
    logic [WORD_W-1:0] rd_data_reg;

    logic [CW-1:0] cnt_dec;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] ptr_dec;
    logic [CW-1:0] ptr_inc;
    logic [EW-1:0] cnt_e;
    logic          full;

    assign cnt_dec = count_reg - CW'(1);
    assign cnt_inc = count_reg + CW'(1);
    assign ptr_dec = ptr_reg - CW'(1);
    assign ptr_inc = ptr_reg + CW'(1);
    assign cnt_e   = EW'(count_reg);
    assign full    = (cnt_e >= EW'(capacity_reg)) || (cnt_e >= EW'(DEPTH));

    assign s_tready = (state_reg == ST_IDLE) && !fin_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        state_next    = state_reg;
        fin_next      = fin_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        value_next    = value_reg;
        popped_next   = popped_reg;
        top_next      = top_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_wa        = count_reg[AW-1:0];
        mem_wd        = s_tdata;
        mem_ra        = cnt_dec[AW-1:0];
        out_load      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (fin_reg)
        begin
            // hold the result until the output register is free
            if (!m_tvalid_reg || m_tready)
            begin
                out_load      = 1'b1;
                m_tvalid_next = 1'b1;
                fin_next      = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        value_next  = s_tdata;
                        popped_next = '0;
                        status_next = STAT_OK;
                        state_next  = ST_READ_TOP;
                        case (op_t'(s_tuser))
                            OP_PUSH:
                            begin
                                if (full)
                                begin
                                    status_next = STAT_OVERFLOW;
                                end
                                else
                                begin
                                    mem_we     = 1'b1;
                                    count_next = cnt_inc;
                                end
                            end
                            OP_POP:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_next = STAT_UNDERFLOW;
                                end
                                else
                                begin
                                    state_next = ST_POP_WAIT;
                                end
                            end
                            OP_REMOVE:
                            begin
                                ptr_next   = count_reg;
                                state_next = ST_SRCH_RD;
                            end
                            default:
                            begin
                                state_next = ST_READ_TOP;
                            end
                        endcase
                    end
                end
                ST_POP_WAIT:
                begin
                    popped_next = rd_data_reg;
                    count_next  = cnt_dec;
                    state_next  = ST_READ_TOP;
                end
                ST_SRCH_RD:
                begin
                    // walk down from the top, one entry per read
                    if (ptr_reg == '0)
                    begin
                        status_next = STAT_NOT_FOUND;
                        state_next  = ST_READ_TOP;
                    end
                    else
                    begin
                        mem_ra     = ptr_dec[AW-1:0];
                        ptr_next   = ptr_dec;
                        state_next = ST_SRCH_CMP;
                    end
                end
                ST_SRCH_CMP:
                begin
                    if (rd_data_reg == value_reg)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = ST_SRCH_RD;
                    end
                end
                ST_SHIFT_RD:
                begin
                    // close the gap: move each entry above the match down one place
                    if (ptr_inc < count_reg)
                    begin
                        mem_ra     = ptr_inc[AW-1:0];
                        state_next = ST_SHIFT_WR;
                    end
                    else
                    begin
                        count_next = cnt_dec;
                        state_next = ST_READ_TOP;
                    end
                end
                ST_SHIFT_WR:
                begin
                    mem_we     = 1'b1;
                    mem_wa     = ptr_reg[AW-1:0];
                    mem_wd     = rd_data_reg;
                    ptr_next   = ptr_inc;
                    state_next = ST_SHIFT_RD;
                end
                ST_READ_TOP:
                begin
                    if (count_reg == '0)
                    begin
                        top_next   = '0;
                        fin_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_TOP_WAIT;
                    end
                end
                ST_TOP_WAIT:
                begin
                    top_next   = rd_data_reg;
                    fin_next   = 1'b1;
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fin_reg      <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            fin_reg      <= fin_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wen)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        value_reg   <= value_next;
        popped_reg  <= popped_next;
        top_reg     <= top_next;
        status_reg  <= status_next;
        if (out_load)
        begin
            out_data_reg <= {(count_reg == '0), cnt_e[CAP_W-1:0], top_reg, popped_reg};
            out_user_reg <= status_reg;
        end
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

`ifndef SYNTH
    assert_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(count_reg) <= EW'(DEPTH))
        else $error("stack count above depth");

    assert_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE || state_reg == ST_SHIFT_WR))
        else $error("stack memory written outside push or shift");

    assert_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT_WR) |-> (ptr_inc < count_reg))
        else $error("shift beyond top of stack");

    assert_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            (count_reg == $past(count_reg) + CW'(1) || count_reg + CW'(1) == $past(count_reg)))
        else $error("stack count moved by more than one");
`endif

endmodule

[dv/lifo_stack_with_value_removal_core_tb.sv]
// Self-checking testbench for the LIFO stack core: push, pop and remove-by-value checks.
module lifo_stack_with_value_removal_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lifo_rm_pkg::*;

    localparam int STACK_DEPTH = 64;
    // Covers the longest remove, with every entry examined and the entries above the match moved.
    localparam int DRAIN_CYCLES = 5 + 4 * STACK_DEPTH + 40;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
    } stack_cmd_t;

    typedef struct packed {
        logic [31:0] popped;
        logic [31:0] top;
        logic [6:0]  count;
        logic        empty;
        status_t     status;
    } stack_resp_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_wen = 1'b0;
    logic [CAP_W-1:0]       cfg_wdata = '0;

    // Shadow of the stack contents and capacity
    logic [31:0] stack_mem [STACK_DEPTH];
    int          stack_cnt = 0;
    logic [6:0]  cap_cfg = CAP_RESET;

    stack_cmd_t  cmd_q[$];
    stack_resp_t resp_pending_q[$];
    logic [31:0] value_pool [6];

    bit idle_on = 1'b1;
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int in_gap = 0;
    int out_wait = 0;
    bit wait_drawn = 1'b0;
    int hold_req = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int err_cnt = 0;

    lifo_stack_with_value_removal_core #(
        .DEPTH(STACK_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wen(cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic stack_resp_t apply_stack_op(op_t op, logic [31:0] val);
        stack_resp_t r;
        int lim;
        int pos;
        int i;
        r = '0;
        r.status = STAT_OK;
        lim = (int'(cap_cfg) < STACK_DEPTH) ? int'(cap_cfg) : STACK_DEPTH;
        case (op)
            OP_PUSH:
            begin
                if (stack_cnt >= lim)
                    r.status = STAT_OVERFLOW;
                else
                begin
                    stack_mem[stack_cnt] = val;
                    stack_cnt++;
                end
            end
            OP_POP:
            begin
                if (stack_cnt == 0)
                    r.status = STAT_UNDERFLOW;
                else
                begin
                    stack_cnt--;
                    r.popped = stack_mem[stack_cnt];
                end
            end
            OP_REMOVE:
            begin
                // search from the top down, then close the gap
                pos = -1;
                for (i = stack_cnt - 1; i >= 0 && pos < 0; i--)
                    if (stack_mem[i] == val)
                        pos = i;
                if (pos < 0)
                    r.status = STAT_NOT_FOUND;
                else
                begin
                    for (i = pos; i < stack_cnt - 1; i++)
                        stack_mem[i] = stack_mem[i + 1];
                    stack_cnt--;
                end
            end
            default: ;
        endcase
        r.top = (stack_cnt > 0) ? stack_mem[stack_cnt - 1] : 32'd0;
        r.count = 7'(stack_cnt);
        r.empty = (stack_cnt == 0);
        return r;
    endfunction

    // Input acceptance, result checking and watchdog, all at the rising edge
    always @(posedge clk)
    begin
        stack_resp_t exp_r;
        bit moved;
        moved = 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            resp_pending_q.push_back(apply_stack_op(op_t'(s_tuser), s_tdata));
            in_taken = 1'b1;
            moved = 1'b1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            out_taken = 1'b1;
            moved = 1'b1;
            if (resp_pending_q.size() == 0)
            begin
                $error("result with no pending operation: tdata %0h tuser %0h",
                       m_tdata, m_tuser);
                err_cnt++;
            end
            else
            begin
                exp_r = resp_pending_q.pop_front();
                if (m_tdata[31:0] !== exp_r.popped)
                begin
                    $error("popped_value: expected %0h, got %0h", exp_r.popped, m_tdata[31:0]);
                    err_cnt++;
                end
                if (m_tdata[63:32] !== exp_r.top)
                begin
                    $error("top_value: expected %0h, got %0h", exp_r.top, m_tdata[63:32]);
                    err_cnt++;
                end
                if (m_tdata[70:64] !== exp_r.count)
                begin
                    $error("entry_count: expected %0d, got %0d", exp_r.count, m_tdata[70:64]);
                    err_cnt++;
                end
                if (m_tdata[71] !== exp_r.empty)
                begin
                    $error("is_empty: expected %0b, got %0b", exp_r.empty, m_tdata[71]);
                    err_cnt++;
                end
                if (m_tuser !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
                    err_cnt++;
                end
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sender: drop valid after an accepted item, then offer the next after its gap
    always @(negedge clk)
    begin
        stack_cmd_t cmd;
        logic nxt_valid;
        nxt_valid = s_tvalid;
        if (in_taken)
        begin
            in_taken = 1'b0;
            nxt_valid = 1'b0;
        end
        if (rst_n && !nxt_valid && cmd_q.size() > 0)
        begin
            if (in_gap > 0)
                in_gap--;
            else
            begin
                cmd = cmd_q.pop_front();
                s_tdata <= cmd.value;
                s_tuser <= cmd.op;
                nxt_valid = 1'b1;
                in_gap = idle_on ? $urandom_range(0, 4) : 0;
            end
        end
        s_tvalid <= nxt_valid;
    end

    // Receiver: draw a stall for every result, plus the occasional long hold-off
    always @(negedge clk)
    begin
        if (out_taken)
        begin
            out_taken = 1'b0;
            wait_drawn = 1'b0;
        end
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (m_tvalid && !wait_drawn)
        begin
            wait_drawn = 1'b1;
            out_wait = idle_on ? $urandom_range(0, 4) : 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (out_wait > 0)
        begin
            out_wait--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic queue_cmd(op_t op, logic [31:0] val);
        stack_cmd_t cmd;
        cmd.op = op;
        cmd.value = val;
        cmd_q.push_back(cmd);
    endtask

    task automatic wait_drained();
        while (cmd_q.size() > 0 || s_tvalid || resp_pending_q.size() > 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_capacity(logic [6:0] cap);
        wait_drained();
        cfg_wen <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_wen <= 1'b0;
        cap_cfg = cap;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 99) < 75)
            return value_pool[$urandom_range(0, 5)];
        return $urandom();
    endfunction

    task automatic queue_random(int n, int push_pct, int pop_pct, int rem_pct);
        int roll;
        for (int k = 0; k < 6; k++)
            value_pool[k] = $urandom();
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                queue_cmd(OP_PUSH, pick_value());
            else if (roll < push_pct + pop_pct)
                queue_cmd(OP_POP, $urandom());
            else if (roll < push_pct + pop_pct + rem_pct)
                queue_cmd(OP_REMOVE, pick_value());
            else
                queue_cmd(OP_NOP, $urandom());
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty-stack errors, extreme words, duplicates, removal at top, middle and bottom
        queue_cmd(OP_POP, 32'h0000_0000);
        queue_cmd(OP_REMOVE, 32'h0000_0000);
        queue_cmd(OP_NOP, 32'hFFFF_FFFF);
        queue_cmd(OP_PUSH, 32'h8000_0000);
        queue_cmd(OP_PUSH, 32'h7FFF_FFFF);
        queue_cmd(OP_PUSH, 32'h0000_0000);
        queue_cmd(OP_PUSH, 32'hFFFF_FFFF);
        queue_cmd(OP_PUSH, 32'h7FFF_FFFF);
        queue_cmd(OP_PUSH, 32'h0000_0005);
        queue_cmd(OP_REMOVE, 32'h7FFF_FFFF);
        queue_cmd(OP_REMOVE, 32'h1234_5678);
        queue_cmd(OP_REMOVE, 32'h0000_0005);
        queue_cmd(OP_REMOVE, 32'h8000_0000);
        queue_cmd(OP_POP, 32'hFFFF_FFFF);
        queue_cmd(OP_NOP, 32'h0000_0000);
        queue_cmd(OP_PUSH, 32'hA5A5_A5A5);

        // capacity lowered below the count: push overflows, pop and remove still work
        set_capacity(7'd1);
        queue_cmd(OP_PUSH, 32'h0000_0001);
        queue_cmd(OP_REMOVE, 32'h0000_0000);
        queue_cmd(OP_POP, 32'h0000_0000);
        queue_cmd(OP_PUSH, 32'h0000_0002);
        queue_cmd(OP_POP, 32'h0000_0000);
        queue_cmd(OP_PUSH, 32'h0000_0003);
        queue_cmd(OP_PUSH, 32'h0000_0004);

        // capacity zero: every push overflows
        set_capacity(7'd0);
        queue_cmd(OP_PUSH, 32'h5A5A_5A5A);
        queue_cmd(OP_POP, 32'h0000_0000);
        queue_cmd(OP_PUSH, 32'hC3C3_C3C3);

        // capacity above depth: fill to the top while the receiver holds off
        set_capacity(7'd127);
        idle_on = 1'b0;
        queue_random(200, 80, 10, 8);
        hold_req = HOLD_CYCLES;

        set_capacity(7'd64);
        idle_on = 1'b1;
        queue_random(150, 45, 30, 20);

        set_capacity(7'd2);
        queue_random(100, 50, 25, 20);

        set_capacity(7'd64);
        idle_on = 1'b0;
        queue_random(150, 70, 10, 15);

        set_capacity(7'd5);
        idle_on = 1'b1;
        queue_random(120, 40, 30, 25);

        set_capacity(7'd0);
        queue_random(60, 40, 30, 25);

        set_capacity(7'($urandom_range(1, 64)));
        queue_random(220, 50, 25, 20);

        set_capacity(7'd127);
        queue_random(200, 30, 40, 25);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (err_cnt == 0 && resp_pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/lifo_rm_pkg.sv
rtl/core/lifo_stack_with_value_removal_core.sv
dv/lifo_stack_with_value_removal_core_tb.sv
